// ===== src/psct_pkg.sv =====
// Package for the packed saturating counter table: codes, state type and defaults.
`default_nettype none

package psct_pkg;

  // Default store size in bytes
  localparam int MemBytesDefault = 256;

  // Field widths
  localparam int CmdW    = 2;
  localparam int ValueW  = 11;
  localparam int KW      = 4;
  localparam int CountW  = 8;
  localparam int StatusW = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 11;

  // Command codes
  localparam logic [CmdW-1:0] CMD_ADD        = 2'd0;
  localparam logic [CmdW-1:0] CMD_QUERY      = 2'd1;
  localparam logic [CmdW-1:0] CMD_COMPLEMENT = 2'd2;

  // Status codes
  localparam logic [StatusW-1:0] STAT_DONE      = 2'd0;
  localparam logic [StatusW-1:0] STAT_RANGE     = 2'd1;
  localparam logic [StatusW-1:0] STAT_SATURATED = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MAX_VALUE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COUNTER_BITS = 2'd1;

  // Register reset values
  localparam logic [ValueW-1:0] RESET_MAX_VALUE    = 11'd255;
  localparam logic [KW-1:0]     RESET_COUNTER_BITS = 4'd1;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_RD_HI,
    S_RD_LO,
    S_EXTRACT,
    S_MODIFY,
    S_WR_HI,
    S_WR_LO,
    S_CPL_RD,
    S_CPL_WR,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== src/packed_saturating_counter_table.sv =====
// Packed saturating counter table: byte store of k-bit counters with add, query, complement.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+------------------------------
//   request  | start, in_cmd, in_value, busy           | taken when start & !busy
//   result   | out_valid, out_count, out_status        | one-cycle strobe, no stall
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data | written when valid & ready
//
// After acceptance, add and query multiply, range-check, read the high and low bytes,
// extract and modify; a non-saturating add then writes back those in the store. An unused
// command or out-of-range value ends at the range check. Complement reads each of the N
// bytes in use and writes it back inverted. A clearing pass after reset zeroes the store,
// with busy high; busy falls in the cycle after the result strobe, cfg_ready low while busy.
// The result is shown for one cycle; the receiver cannot hold it off.
`default_nettype none

module packed_saturating_counter_table
  import psct_pkg::*;
#(
  parameter int MEM_BYTES = MemBytesDefault
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [CmdW-1:0]    in_cmd,
  input  wire logic [ValueW-1:0]  in_value,
  // result
  output logic                    out_valid,
  output logic [CountW-1:0]       out_count,
  output logic [StatusW-1:0]      out_status,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgDatW-1:0] cfg_data
);

  // Derived sizes
  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam int CW = $clog2(MEM_BYTES + 1);
  localparam logic [20:0] MEM_BITS    = 21'(MEM_BYTES * 8);
  localparam logic [16:0] MEM_BYTES_W = 17'(MEM_BYTES);
  localparam logic [CW-1:0] LAST_BYTE = CW'(MEM_BYTES - 1);

  // Byte store
  logic [7:0] mem [MEM_BYTES];
  logic [7:0] rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0] wr_data;
  logic wr_en;

  // Control and payload registers
  state_t state_r, state_nxt;
  logic [ValueW-1:0] max_value_r;
  logic [KW-1:0] counter_bits_r;
  logic [CmdW-1:0] cmd_r, cmd_nxt;
  logic [ValueW-1:0] value_r, value_nxt;
  logic [15:0] prod_r, prod_nxt;
  logic [ValueW-1:0] byte_r, byte_nxt;
  logic [3:0] shift_r, shift_nxt;
  logic has_lo_r, has_lo_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic [15:0] w_r, w_nxt;
  logic [7:0] c_r, c_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] limit_r, limit_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [StatusW-1:0] status_r, status_nxt;

  // Working signals
  logic [KW-1:0] k;
  logic [7:0] mask;
  logic [11:0] mul_a;
  logic [15:0] mul_p;
  logic [16:0] used;
  logic [4:0] shift_calc;
  logic [7:0] lo;
  logic [15:0] w_cat;
  logic [15:0] ins_mask;
  logic [7:0] c_inc;

  // Effective counter width: zero acts as one, above eight acts as eight
  always_comb begin
    if (counter_bits_r == '0) begin
      k = KW'(1);
    end else if (counter_bits_r > KW'(8)) begin
      k = KW'(8);
    end else begin
      k = counter_bits_r;
    end
  end

  assign mask = 8'((9'd1 << k) - 9'd1);

  // Shared multiplier: bit position for add/query, extent for complement
  assign mul_a = (cmd_r == CMD_COMPLEMENT) ? (12'(max_value_r) + 12'd1) : 12'(value_r);
  assign mul_p = 16'(mul_a) * 16'(k);

  assign used       = (17'(prod_r) + 17'd7) >> 3;
  assign shift_calc = 5'd16 - 5'(prod_r[2:0]) - 5'(k);
  assign lo         = has_lo_r ? rd_data_r : 8'd0;
  assign w_cat      = {hi_r, lo};
  assign ins_mask   = 16'(mask) << shift_r;
  assign c_inc      = c_r + 8'd1;

  // Registers are written only while idle, so no request sees them change mid-way
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_value_r    <= RESET_MAX_VALUE;
      counter_bits_r <= RESET_COUNTER_BITS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_VALUE:    max_value_r    <= cfg_data;
        CFG_COUNTER_BITS: counter_bits_r <= cfg_data[KW-1:0];
        default: ;
      endcase
    end
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    value_r  <= value_nxt;
    prod_r   <= prod_nxt;
    byte_r   <= byte_nxt;
    shift_r  <= shift_nxt;
    has_lo_r <= has_lo_nxt;
    hi_r     <= hi_nxt;
    w_r      <= w_nxt;
    c_r      <= c_nxt;
    limit_r  <= limit_nxt;
    count_r  <= count_nxt;
    status_r <= status_nxt;
  end

  // Sequencer: next state, store access and datapath updates
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd_nxt    = cmd_r;
    value_nxt  = value_r;
    prod_nxt   = prod_r;
    byte_nxt   = byte_r;
    shift_nxt  = shift_r;
    has_lo_nxt = has_lo_r;
    hi_nxt     = hi_r;
    w_nxt      = w_r;
    c_nxt      = c_r;
    limit_nxt  = limit_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    rd_addr    = AW'(byte_r);
    wr_addr    = cnt_r[AW-1:0];
    wr_data    = 8'd0;
    wr_en      = 1'b0;

    unique case (state_r)
      // Zero the store, one byte after another, after reset
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[AW-1:0];
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST_BYTE) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_cmd;
          value_nxt  = in_value;
          count_nxt  = '0;
          status_nxt = STAT_DONE;
          state_nxt  = S_MUL;
        end
      end

      S_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_CHECK;
      end

      // Range check for add/query, extent for complement
      S_CHECK: begin
        if (cmd_r == CMD_COMPLEMENT) begin
          limit_nxt = (used > MEM_BYTES_W) ? CW'(MEM_BYTES_W) : CW'(used);
          cnt_nxt   = '0;
          state_nxt = S_CPL_RD;
        end else if (cmd_r == CMD_ADD || cmd_r == CMD_QUERY) begin
          if (value_r > max_value_r || (21'(prod_r) + 21'(k)) > MEM_BITS) begin
            status_nxt = STAT_RANGE;
            state_nxt  = S_DONE;
          end else begin
            byte_nxt   = ValueW'(prod_r >> 3);
            shift_nxt  = shift_calc[3:0];
            has_lo_nxt = (17'(prod_r >> 3) + 17'd1) < MEM_BYTES_W;
            state_nxt  = S_RD_HI;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_RD_HI: begin
        rd_addr   = AW'(byte_r);
        state_nxt = S_RD_LO;
      end

      S_RD_LO: begin
        rd_addr   = AW'(12'(byte_r) + 12'd1);
        hi_nxt    = rd_data_r;
        state_nxt = S_EXTRACT;
      end

      // Pull the counter out of the two-byte window
      S_EXTRACT: begin
        w_nxt     = w_cat;
        c_nxt     = 8'(w_cat >> shift_r) & mask;
        state_nxt = S_MODIFY;
      end

      S_MODIFY: begin
        if (cmd_r == CMD_QUERY) begin
          count_nxt = c_r;
          state_nxt = S_DONE;
        end else if (c_r == mask) begin
          count_nxt  = c_r;
          status_nxt = STAT_SATURATED;
          state_nxt  = S_DONE;
        end else begin
          w_nxt     = (w_r & ~ins_mask) | (16'(c_inc) << shift_r);
          count_nxt = c_inc;
          state_nxt = S_WR_HI;
        end
      end

      S_WR_HI: begin
        wr_en     = 1'b1;
        wr_addr   = AW'(byte_r);
        wr_data   = w_r[15:8];
        state_nxt = S_WR_LO;
      end

      S_WR_LO: begin
        wr_en     = has_lo_r;
        wr_addr   = AW'(12'(byte_r) + 12'd1);
        wr_data   = w_r[7:0];
        state_nxt = S_DONE;
      end

      // Complement: read a byte, write it back inverted
      S_CPL_RD: begin
        rd_addr = cnt_r[AW-1:0];
        if (cnt_r == limit_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CPL_WR;
        end
      end

      S_CPL_WR: begin
        wr_en     = 1'b1;
        wr_addr   = cnt_r[AW-1:0];
        wr_data   = ~rd_data_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_CPL_RD;
      end

      S_DONE: begin
        cnt_nxt   = '0;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs
  assign busy       = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_DONE);
  assign out_count  = count_r;
  assign out_status = status_r;

`ifndef SYNTH
  // Reset always starts the clearing pass, so no request is taken straight after it
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  // An accepted request keeps the block busy
  a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // After the result strobe the block is ready again
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("block not idle after result");

  // Out-of-range results carry no count
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_RANGE |-> out_count == '0)
    else $error("out-of-range result with nonzero count");

  // A saturated add reports a full, nonzero counter
  a_sat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_SATURATED |-> out_count == mask && out_count != '0)
    else $error("saturation result with wrong count");
`endif

endmodule

`default_nettype wire

// ===== bench/psct_checker.sv =====
// Checker for the packed saturating counter table: tracks the counter store and checks results.
`timescale 1ns / 1ps

module psct_checker
  import psct_pkg::*;
#(
  parameter int MEM_BYTES = MemBytesDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [CmdW-1:0]    in_cmd,
  input  logic [ValueW-1:0]  in_value,
  input  logic               out_valid,
  input  logic [CountW-1:0]  out_count,
  input  logic [StatusW-1:0] out_status,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDatW-1:0] cfg_data,
  output int unsigned        fail_count,
  output int unsigned        awaiting
);

  typedef struct packed {
    logic [CountW-1:0]  count;
    logic [StatusW-1:0] status;
  } tally_res_t;

  // Shadow copy of the store and the two registers
  logic [7:0]        tally_bytes [MEM_BYTES];
  logic [ValueW-1:0] lim_reg;
  logic [KW-1:0]     width_reg;

  // Results still owed by the block, oldest first
  tally_res_t due_results [$];

  initial begin
    fail_count = 0;
    awaiting   = 0;
  end

  // Apply one request to the shadow store and return the result it should produce
  function automatic tally_res_t tally_step(input logic [CmdW-1:0] cmd,
                                            input logic [ValueW-1:0] v);
    int unsigned k, span, p, b, off, sh, mask, lo, w, c;
    tally_res_t  r;
    r.count  = '0;
    r.status = STAT_DONE;
    // zero width behaves as one bit, anything past eight as eight
    k = (width_reg == 0) ? 1 : (width_reg > 8) ? 8 : int'(width_reg);
    if (cmd == CMD_COMPLEMENT) begin
      span = ((int'(lim_reg) + 1) * k + 7) >> 3;
      if (span > MEM_BYTES) span = MEM_BYTES;
      for (int i = 0; i < span; i++) tally_bytes[i] = ~tally_bytes[i];
    end else if (cmd == CMD_ADD || cmd == CMD_QUERY) begin
      p = int'(v) * k;
      if (v > lim_reg || p + k > MEM_BYTES * 8) begin
        r.status = STAT_RANGE;
      end else begin
        // counter sits in a 16-bit window of this byte and the next, MSB first
        b    = p >> 3;
        off  = p & 7;
        sh   = 16 - off - k;
        mask = (1 << k) - 1;
        lo   = (b + 1 < MEM_BYTES) ? int'(tally_bytes[b + 1]) : 0;
        w    = (int'(tally_bytes[b]) << 8) | lo;
        c    = (w >> sh) & mask;
        if (cmd == CMD_QUERY) begin
          r.count = c[CountW-1:0];
        end else if (c == mask) begin
          r.count  = c[CountW-1:0];
          r.status = STAT_SATURATED;
        end else begin
          c++;
          w = (w & ~(mask << sh)) | (c << sh);
          tally_bytes[b] = w[15:8];
          if (b + 1 < MEM_BYTES) tally_bytes[b + 1] = w[7:0];
          r.count = c[CountW-1:0];
        end
      end
    end
    return r;
  endfunction

  // Watch all three channels at the rising edge
  always @(posedge clk) begin
    tally_res_t want;
    if (!rst_n) begin
      for (int i = 0; i < MEM_BYTES; i++) tally_bytes[i] = 8'h00;
      lim_reg   = RESET_MAX_VALUE;
      width_reg = RESET_COUNTER_BITS;
      due_results.delete();
    end else begin
      // result strobe: compare against the oldest request
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $error("result with no request outstanding: count %0d status %0d",
                 out_count, out_status);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (out_count !== want.count || out_status !== want.status) begin
            if (out_count !== want.count)
              $error("count mismatch: expected %0d, actual %0d", want.count, out_count);
            if (out_status !== want.status)
              $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
            fail_count++;
          end
        end
      end
      // register writes; spare indexes are ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_VALUE:    lim_reg   = cfg_data[ValueW-1:0];
          CFG_COUNTER_BITS: width_reg = cfg_data[KW-1:0];
          default: ;
        endcase
      end
      // accepted request
      if (start && !busy) due_results.push_back(tally_step(in_cmd, in_value));
    end
    awaiting = due_results.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the packed saturating counter table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top
  import psct_pkg::*;
();

  localparam logic [CmdW-1:0]    CMD_SPARE  = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPARE  = 2'd3;
  localparam int unsigned        CycleLimit = 2_000_000;
  localparam int unsigned        StoreBits  = MemBytesDefault * 8;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               start      = 1'b0;
  logic [CmdW-1:0]    in_cmd     = '0;
  logic [ValueW-1:0]  in_value   = '0;
  logic               cfg_valid  = 1'b0;
  logic [CfgIdxW-1:0] cfg_index  = '0;
  logic [CfgDatW-1:0] cfg_data   = '0;
  logic               busy;
  logic               out_valid;
  logic [CountW-1:0]  out_count;
  logic [StatusW-1:0] out_status;
  logic               cfg_ready;
  int unsigned        fail_count;
  int unsigned        awaiting;

  // Stimulus shaping state
  int unsigned        idle_pct   = 0;
  int unsigned        cur_max    = 255;
  int unsigned        cur_top    = 255;
  int unsigned        n_requests = 0;
  int unsigned        n_settings = 1;
  int unsigned        cyc        = 0;
  logic [ValueW-1:0]  hot [4];
  int unsigned        hot_n      = 4;

  always #5 clk = ~clk;

  packed_saturating_counter_table u_top (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_value,
    .out_valid, .out_count, .out_status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  psct_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_value,
    .out_valid, .out_count, .out_status,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .awaiting
  );

  function automatic logic [CmdW-1:0] pick_cmd();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 58) return CMD_ADD;
    if (sel < 90) return CMD_QUERY;
    if (sel < 95) return CMD_COMPLEMENT;
    return CMD_SPARE;
  endfunction

  // Mostly legal values, biased to a hot set and the top of the usable range
  function automatic logic [ValueW-1:0] pick_value();
    int unsigned sel, v;
    sel = $urandom_range(0, 99);
    if (sel < 35) return hot[$urandom_range(0, hot_n - 1)];
    if (sel < 70) return ValueW'($urandom_range(0, cur_max));
    if (sel < 85) begin
      v = cur_top + 1 - $urandom_range(0, 3);
      if (v > cur_top && cur_top == 2047) v = cur_top;
      if (v > 2047 || int'(v) < 0) v = 0;
      return ValueW'(v);
    end
    return ValueW'($urandom_range(0, 2047));
  endfunction

  // One request: each cycle the sender idles with chance idle_pct, else offers it
  task automatic issue(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] val);
    logic taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
      end else begin
        start    <= 1'b1;
        in_cmd   <= cmd;
        in_value <= val;
      end
      @(posedge clk);
      taken = start && !busy;
    end
    n_requests++;
  endtask

  // Stop sending until every owed result has come back
  task automatic hold_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] dat);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= dat;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Repeated adds on one value, to drive its counter into saturation
  task automatic pump(input logic [ValueW-1:0] val, input int unsigned reps);
    repeat (reps) issue(CMD_ADD, val);
    issue(CMD_QUERY, val);
  endtask

  // New register setting, then a block of random requests
  task automatic run_phase(input logic [CfgDatW-1:0] lim, input logic [CfgDatW-1:0] kdat,
                           input int unsigned n_items, input int unsigned idle);
    int unsigned k;
    hold_until_drained();
    cfg_write(CFG_MAX_VALUE, lim);
    cfg_write(CFG_COUNTER_BITS, kdat);
    k = (kdat[KW-1:0] == 0) ? 1 : (kdat[KW-1:0] > 8) ? 8 : int'(kdat[KW-1:0]);
    cur_max = lim;
    cur_top = StoreBits / k - 1;
    if (cur_top > cur_max) cur_top = cur_max;
    hot[0] = 0;
    hot[1] = ValueW'(cur_top);
    hot[2] = ValueW'($urandom_range(0, cur_top));
    hot[3] = ValueW'($urandom_range(0, cur_top));
    hot_n    = (k >= 6) ? 2 : 4;
    idle_pct = idle;
    n_settings++;
    for (int i = 0; i < n_items; i++) begin
      // occasional full pause mid-phase
      if ($urandom_range(0, 39) == 0) hold_until_drained();
      issue(pick_cmd(), pick_value());
    end
  endtask

  // Watchdog
  initial begin
    while (cyc < CycleLimit) begin
      @(posedge clk);
      cyc++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset setting, one-bit counters
    issue(CMD_ADD, 11'd0);
    issue(CMD_ADD, 11'd0);
    issue(CMD_QUERY, 11'd0);
    issue(CMD_QUERY, 11'd1);
    issue(CMD_ADD, 11'd255);
    issue(CMD_QUERY, 11'd255);
    issue(CMD_QUERY, 11'd256);
    issue(CMD_ADD, 11'd2047);
    issue(CMD_SPARE, 11'd2047);
    issue(CMD_SPARE, 11'd0);
    issue(CMD_ADD, 11'd7);
    issue(CMD_ADD, 11'd8);
    issue(CMD_COMPLEMENT, 11'd0);
    issue(CMD_QUERY, 11'd0);
    issue(CMD_QUERY, 11'd9);
    issue(CMD_COMPLEMENT, 11'd2047);
    issue(CMD_QUERY, 11'd0);
    issue(CMD_ADD, 11'd128);
    issue(CMD_QUERY, 11'd128);

    // Register settings, extremes included
    run_phase(11'd2047, 11'd1, 45, 0);
    run_phase(11'd0, 11'd8, 45, 58);
    run_phase(11'd255, 11'd8, 45, 21);
    pump(11'd17, 256);
    run_phase(11'd300, 11'd15, 45, 0);
    hold_until_drained();
    cfg_write(CFG_SPARE, 11'h7FF);
    issue(CMD_QUERY, 11'd300);
    run_phase(11'd100, 11'd3, 45, 58);
    pump(11'd5, 10);
    run_phase(11'd2047, 11'd0, 45, 21);
    run_phase(11'd680, 11'd3, 45, 0);
    run_phase(11'd40, 11'h7F5, 45, 58);
    pump(11'd3, 33);
    run_phase(11'd2047, 11'd8, 45, 21);

    // Wind down: everything back, then allow for a full complement pass
    hold_until_drained();
    repeat (2 * MemBytesDefault + 16) @(posedge clk);

    $display("summary: %0d requests over %0d register settings, sender idle 0/21/58 per cent",
             n_requests, n_settings);
    $display("summary: saturation, straddling counters, complement and out-of-range covered");
    if (fail_count == 0 && awaiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
